// ----- rtl/icc_pkg.sv -----
// ----------------------------------------------------------------------------
// icc_pkg
// Shared types and constants of the clamped 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package icc_pkg;

    localparam int STORE_ROWS = 4;
    localparam int NUM_TAPS   = 9;
    localparam int NUM_CHAN   = 3;

    localparam logic [7:0] SAT_VALUE = 8'd255;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic [2:0] REG_IMAGE_ROWS    = 3'd0;
    localparam logic [2:0] REG_IMAGE_COLS    = 3'd1;
    localparam logic [2:0] REG_COEF_TAPS_0_3 = 3'd2;
    localparam logic [2:0] REG_COEF_TAPS_4_7 = 3'd3;
    localparam logic [2:0] REG_COEF_TAP_8    = 3'd4;

    typedef logic [23:0] t_pix;
    typedef logic [NUM_TAPS-1:0][23:0] t_window;
    typedef logic [NUM_TAPS-1:0][15:0] t_taps;

    typedef struct packed {
        logic [11:0] row;
        logic [10:0] col;
        logic        last;
    } t_meta;

    typedef struct packed {
        logic       valid;
        logic [1:0] sel_up;
        logic [1:0] sel_mid;
        logic [1:0] sel_dn;
        logic       first_col;
        t_meta      meta;
    } t_emit;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        t_meta      meta;
    } t_res;

endpackage

// ----- rtl/icc_ram.sv -----
// ----------------------------------------------------------------------------
// icc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module icc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ----- rtl/icc_ctrl.sv -----
// ----------------------------------------------------------------------------
// icc_ctrl
// Input/output position counters, store write and read addressing, and the
// decision whether a transaction releases an output pixel.
// ----------------------------------------------------------------------------
module icc_ctrl #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_func,
    input  icc_pkg::t_pix               i_pixel,
    input  logic [12:0]                 i_image_rows,
    input  logic [11:0]                 i_image_cols,
    output logic                        o_we,
    output logic [1:0]                  o_wslot,
    output logic [$clog2(MAX_COLS)-1:0] o_wcol,
    output icc_pkg::t_pix               o_wdata,
    output logic [$clog2(MAX_COLS)-1:0] o_rcol_a,
    output logic [$clog2(MAX_COLS)-1:0] o_rcol_b,
    output icc_pkg::t_emit              o_emit
);

    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int CA = $clog2(MAX_COLS);

    logic [RW-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic [CW-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [RW-1:0] rows, nr, up;
    logic [CW-1:0] cols, nc;
    logic          we, done, ok, last;

    always_comb begin
        if (i_image_rows == '0) begin
            rows = RW'(1);
        end else if (int'(i_image_rows) > MAX_ROWS) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(i_image_rows);
        end
        if (i_image_cols == '0) begin
            cols = CW'(1);
        end else if (int'(i_image_cols) > MAX_COLS) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = CW'(i_image_cols);
        end
    end

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        we        = 1'b0;
        ok        = 1'b0;
        last      = 1'b0;
        done      = 1'b0;
        if (n_in_col >= cols) begin
            n_in_col = '0;
            n_in_row = n_in_row + 1'b1;
        end
        if (n_out_col >= cols) begin
            n_out_col = '0;
            n_out_row = n_out_row + 1'b1;
        end
        o_wslot = n_in_row[1:0];
        o_wcol  = n_in_col[CA-1:0];
        nr = (n_out_row + 1'b1 < rows) ? n_out_row + 1'b1 : rows - 1'b1;
        nc = (n_out_col + 1'b1 < cols) ? n_out_col + 1'b1 : cols - 1'b1;
        up = (n_out_row == '0) ? '0 : n_out_row - 1'b1;
        o_rcol_a = nc[CA-1:0];
        o_rcol_b = n_out_col[CA-1:0];
        o_emit.sel_up    = up[1:0];
        o_emit.sel_mid   = n_out_row[1:0];
        o_emit.sel_dn    = nr[1:0];
        o_emit.first_col = (n_out_col == '0);
        o_emit.meta.row  = 12'(n_out_row);
        o_emit.meta.col  = 11'(n_out_col);
        if (n_out_row >= rows) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
        end else begin
            done = (n_in_row >= rows);
            if (i_func == icc_pkg::FUNC_PIXEL && !done) begin
                we       = 1'b1;
                n_in_col = n_in_col + 1'b1;
                if (n_in_col >= cols) begin
                    n_in_col = '0;
                    n_in_row = n_in_row + 1'b1;
                end
                done = (n_in_row >= rows);
            end
            ok = done || (n_in_row > nr) || (n_in_row == nr && n_in_col > nc);
            if (ok) begin
                last = (n_out_row == rows - 1'b1) && (n_out_col == cols - 1'b1);
                if (last) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end else begin
                    n_out_col = n_out_col + 1'b1;
                    if (n_out_col >= cols) begin
                        n_out_col = '0;
                        n_out_row = n_out_row + 1'b1;
                    end
                end
            end
        end
        o_emit.meta.last = last;
        o_emit.valid     = i_accept && ok;
        o_we             = i_accept && we;
        o_wdata          = i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else if (i_accept) begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

endmodule

// ----- rtl/icc_mac.sv -----
// ----------------------------------------------------------------------------
// icc_mac
// Tap products, then nine accumulate stages with per-tap truncation toward
// zero, then saturation of each channel.
// ----------------------------------------------------------------------------
module icc_mac (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  icc_pkg::t_window i_win,
    input  icc_pkg::t_meta  i_meta,
    input  icc_pkg::t_taps  i_taps,
    output logic            o_vld,
    output icc_pkg::t_res   o_res
);

    localparam int NT = icc_pkg::NUM_TAPS;
    localparam int NC = icc_pkg::NUM_CHAN;

    logic                r_vld  [NT+1];
    icc_pkg::t_meta      r_meta [NT+1];
    logic signed [24:0]  r_prd  [NT][NT][NC];
    logic signed [19:0]  r_sum  [1:NT][NC];
    logic        [7:0]   sat    [NC];

    function automatic logic signed [19:0] acc_step(
        input logic signed [19:0] sum,
        input logic signed [24:0] x
    );
        logic signed [29:0] t;
        logic signed [29:0] f;
        t = {{2{sum[19]}}, sum, 8'h00} + {{5{x[24]}}, x};
        f = t >>> 8;
        if (t[29] && t[7:0] != 8'h00) begin
            f = f + 30'sd1;
        end
        return f[19:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s <= NT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta[0] <= i_meta;
            for (int k = 0; k < NT; k++) begin
                for (int c = 0; c < NC; c++) begin
                    r_prd[0][k][c] <= $signed({1'b0, i_win[k][8*c +: 8]})
                                    * $signed(i_taps[k]);
                end
            end
            for (int s = 1; s <= NT; s++) begin
                r_meta[s] <= r_meta[s-1];
            end
            for (int s = 1; s < NT; s++) begin
                r_prd[s]  <= r_prd[s-1];
            end
            for (int c = 0; c < NC; c++) begin
                r_sum[1][c] <= acc_step(20'sd0, r_prd[0][0][c]);
                for (int s = 2; s <= NT; s++) begin
                    r_sum[s][c] <= acc_step(r_sum[s-1][c], r_prd[s-1][s-1][c]);
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            if (r_sum[NT][c][19] || r_sum[NT][c][18:8] != '0) begin
                sat[c] = icc_pkg::SAT_VALUE;
            end else begin
                sat[c] = r_sum[NT][c][7:0];
            end
        end
        o_vld       = r_vld[NT];
        o_res.red   = sat[0];
        o_res.green = sat[1];
        o_res.blue  = sat[2];
        o_res.meta  = r_meta[NT];
    end

endmodule

// ----- rtl/image_conv3x3_clamped.sv -----
// ----------------------------------------------------------------------------
// image_conv3x3_clamped
// Streaming 3x3 RGB convolution with edge clamping over a four-row store.
//
//   channel | direction | handshake           | payload
//   input   | in        | i_valid / o_ready   | i_func, i_chan_red/green/blue
//   output  | out       | o_valid / i_ready   | o_res_*, o_res_row/col, o_frame_end
//   config  | in        | psel/penable/pready | paddr, pwdata, prdata (64 bit)
//
// One transaction per clock while not stalled; an output pixel is released
// by an input transaction and passes through store read, window, products,
// nine accumulate stages and the output queue.
// The store is four RAMs, one per row slot, each read at two columns a cycle.
// A two-entry output queue keeps input flowing while one result waits; the
// pipeline stalls only when both entries are full.
// Reset is synchronous; the store needs no clearing.
// ----------------------------------------------------------------------------
module image_conv3x3_clamped #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_chan_red,
    input  logic [7:0]  i_chan_green,
    input  logic [7:0]  i_chan_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_res_red,
    output logic [7:0]  o_res_green,
    output logic [7:0]  o_res_blue,
    output logic [11:0] o_res_row,
    output logic [10:0] o_res_col,
    output logic        o_frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int CA = $clog2(MAX_COLS);
    localparam int NS = icc_pkg::STORE_ROWS;

    logic [12:0] r_image_rows;
    logic [11:0] r_image_cols;
    logic [63:0] r_coef_0_3, r_coef_4_7;
    logic [15:0] r_coef_8;

    logic           en, accept, we, push, pop;
    logic [1:0]     wslot;
    logic [CA-1:0]  wcol, rcol_a, rcol_b;
    icc_pkg::t_pix  wdata;
    icc_pkg::t_emit emit;
    icc_pkg::t_taps taps;

    icc_pkg::t_pix  rd_a [NS];
    icc_pkg::t_pix  rd_b [NS];
    icc_pkg::t_pix  col_l [NS];
    icc_pkg::t_pix  col_c [NS];
    icc_pkg::t_pix  col_r [NS];
    icc_pkg::t_pix  r_prev [NS];

    icc_pkg::t_emit  r_s1;
    logic            r_fwd_we;
    logic [1:0]      r_fwd_slot;
    logic [CA-1:0]   r_fwd_col, r_rcol_a, r_rcol_b;
    icc_pkg::t_pix   r_fwd_data;

    logic             r_win_vld;
    icc_pkg::t_meta   r_win_meta;
    icc_pkg::t_window r_win, win;

    logic            mac_vld;
    icc_pkg::t_res   mac_res;
    icc_pkg::t_res   r_q [2];
    logic [1:0]      r_cnt;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows <= 13'd1;
            r_image_cols <= 12'd1;
            r_coef_0_3   <= '0;
            r_coef_4_7   <= '0;
            r_coef_8     <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
                icc_pkg::REG_IMAGE_ROWS:    r_image_rows <= pwdata[12:0];
                icc_pkg::REG_IMAGE_COLS:    r_image_cols <= pwdata[11:0];
                icc_pkg::REG_COEF_TAPS_0_3: r_coef_0_3   <= pwdata;
                icc_pkg::REG_COEF_TAPS_4_7: r_coef_4_7   <= pwdata;
                icc_pkg::REG_COEF_TAP_8:    r_coef_8     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            icc_pkg::REG_IMAGE_ROWS:    prdata = 64'(r_image_rows);
            icc_pkg::REG_IMAGE_COLS:    prdata = 64'(r_image_cols);
            icc_pkg::REG_COEF_TAPS_0_3: prdata = r_coef_0_3;
            icc_pkg::REG_COEF_TAPS_4_7: prdata = r_coef_4_7;
            icc_pkg::REG_COEF_TAP_8:    prdata = 64'(r_coef_8);
            default:                    prdata = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            taps[k]     = r_coef_0_3[16*k +: 16];
            taps[k + 4] = r_coef_4_7[16*k +: 16];
        end
        taps[8] = r_coef_8;
    end

    // flow control
    assign en      = !(r_cnt == 2'd2 && !i_ready);
    assign o_ready = en;
    assign accept  = i_valid && o_ready;

    icc_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_func       (i_func),
        .i_pixel      ({i_chan_blue, i_chan_green, i_chan_red}),
        .i_image_rows (r_image_rows),
        .i_image_cols (r_image_cols),
        .o_we         (we),
        .o_wslot      (wslot),
        .o_wcol       (wcol),
        .o_wdata      (wdata),
        .o_rcol_a     (rcol_a),
        .o_rcol_b     (rcol_b),
        .o_emit       (emit)
    );

    for (genvar s = 0; s < NS; s++) begin : g_store
        icc_ram #(
            .WIDTH (24),
            .DEPTH (MAX_COLS)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (we && wslot == 2'(s)),
            .i_waddr   (wcol),
            .i_wdata   (wdata),
            .i_re      (en),
            .i_raddr_a (rcol_a),
            .i_raddr_b (rcol_b),
            .o_rdata_a (rd_a[s]),
            .o_rdata_b (rd_b[s])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_fwd_we   <= 1'b0;
        end else if (en) begin
            r_s1.valid     <= emit.valid;
            r_fwd_we       <= we;
            r_s1.sel_up    <= emit.sel_up;
            r_s1.sel_mid   <= emit.sel_mid;
            r_s1.sel_dn    <= emit.sel_dn;
            r_s1.first_col <= emit.first_col;
            r_s1.meta      <= emit.meta;
            r_fwd_slot     <= wslot;
            r_fwd_col      <= wcol;
            r_fwd_data     <= wdata;
            r_rcol_a       <= rcol_a;
            r_rcol_b       <= rcol_b;
        end
    end

    // read-during-write bypass and window assembly
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            if (r_fwd_we && r_fwd_slot == 2'(s) && r_fwd_col == r_rcol_b) begin
                col_c[s] = r_fwd_data;
            end else begin
                col_c[s] = rd_b[s];
            end
            if (r_fwd_we && r_fwd_slot == 2'(s) && r_fwd_col == r_rcol_a) begin
                col_r[s] = r_fwd_data;
            end else begin
                col_r[s] = rd_a[s];
            end
            col_l[s] = r_s1.first_col ? col_c[s] : r_prev[s];
        end
        win[0] = col_l[r_s1.sel_up];
        win[1] = col_c[r_s1.sel_up];
        win[2] = col_r[r_s1.sel_up];
        win[3] = col_l[r_s1.sel_mid];
        win[4] = col_c[r_s1.sel_mid];
        win[5] = col_r[r_s1.sel_mid];
        win[6] = col_l[r_s1.sel_dn];
        win[7] = col_c[r_s1.sel_dn];
        win[8] = col_r[r_s1.sel_dn];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_vld <= 1'b0;
        end else if (en) begin
            r_win_vld <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_win      <= win;
            r_win_meta <= r_s1.meta;
            if (r_s1.valid) begin
                r_prev <= col_c;
            end
        end
    end

    icc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_win_vld),
        .i_win   (r_win),
        .i_meta  (r_win_meta),
        .i_taps  (taps),
        .o_vld   (mac_vld),
        .o_res   (mac_res)
    );

    // output queue
    assign push = en && mac_vld;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_q[0] <= mac_res;
                end else begin
                    r_q[1] <= mac_res;
                end
            end
            2'b01: begin
                r_q[0] <= r_q[1];
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_q[0] <= mac_res;
                end else begin
                    r_q[0] <= r_q[1];
                    r_q[1] <= mac_res;
                end
            end
            default: ;
        endcase
    end

    assign o_valid     = (r_cnt != 2'd0);
    assign o_res_red   = r_q[0].red;
    assign o_res_green = r_q[0].green;
    assign o_res_blue  = r_q[0].blue;
    assign o_res_row   = r_q[0].meta.row;
    assign o_res_col   = r_q[0].meta.col;
    assign o_frame_end = r_q[0].meta.last;

endmodule
